[rtl/core/csff_pkg.sv]
// Package with shared constants, operation codes and control structs of the counted set.
package csff_pkg;

   // Widths of the item fields.
   localparam int OP_W = 2;
   localparam int IDX_W = 10;
   localparam int COUNT_W = 16;

   // Defaults of the top-level parameters.
   localparam int SLOTS_DEF = 1024;
   localparam int GROUP_SIZE_DEF = 32;

   // Saturation value of a slot count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND_LOW = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND_HIGH = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic prep;
      logic prep2;
      logic jump;
      logic advance;
      logic hit;
      logic miss;
      logic update;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_update;
      logic range_ok;
      logic grp_empty;
      logic jump_miss;
      logic at_end;
      logic data_nz;
      logic out_free;
   } status_type;

endpackage

[rtl/core/csff_if.sv]
// Channel interfaces for request and response words.
interface csff_req_if;
   logic valid;
   logic ready;
   logic [csff_pkg::OP_W-1:0] operation;
   logic [csff_pkg::IDX_W-1:0] slot;
   logic [csff_pkg::IDX_W-1:0] range_low;
   logic [csff_pkg::IDX_W-1:0] range_high;

   modport source(output valid, output operation, output slot, output range_low,
      output range_high, input ready);
   modport sink(input valid, input operation, input slot, input range_low,
      input range_high, output ready);
endinterface

interface csff_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic [csff_pkg::IDX_W-1:0] index;
   logic error;

   modport source(output valid, output found, output index, output error, input ready);
   modport sink(input valid, input found, input index, input error, output ready);
endinterface

[rtl/core/csff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module csff_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/csff_ctrl.sv]
// Controller state machine that sequences clearing, updates and range searches.
module csff_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  csff_pkg::status_type status,
   output csff_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_PREP = 4'd2;
   localparam logic [3:0] ST_UPD = 4'd3;
   localparam logic [3:0] ST_PREP2 = 4'd4;
   localparam logic [3:0] ST_STEP = 4'd5;
   localparam logic [3:0] ST_CHECK = 4'd6;
   localparam logic [3:0] ST_RESULT = 4'd7;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.is_update) begin
               state_in = ST_UPD;
            end else if (!status.range_ok) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_PREP2;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in = ST_RESULT;
         end
         ST_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!status.grp_empty) begin
               state_in = ST_CHECK;
            end else if (status.jump_miss) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.jump = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.data_nz) begin
               cmd.hit = 1'b1;
               state_in = ST_RESULT;
            end else if (status.at_end) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.advance = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // The preparation of a find is always followed by a search step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP2) |=> (state_ff == ST_STEP))
      else $error("search did not start after preparation");

   // A request is taken only in the idle state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE) && req_valid)
      else $error("request loaded outside idle");

   // An update always leads to the result state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (state_ff == ST_RESULT))
      else $error("update did not produce a result");

endmodule

[rtl/core/csff_dp.sv]
// Datapath with slot count memory, group sums, search pointers and result registers.
module csff_dp #(
   parameter int SLOTS = csff_pkg::SLOTS_DEF,
   parameter int GROUP_SIZE = csff_pkg::GROUP_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csff_pkg::cmd_type             cmd,
   output csff_pkg::status_type          status,
   input  logic [csff_pkg::OP_W-1:0]     req_operation,
   input  logic [csff_pkg::IDX_W-1:0]    req_slot,
   input  logic [csff_pkg::IDX_W-1:0]    req_range_low,
   input  logic [csff_pkg::IDX_W-1:0]    req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [csff_pkg::IDX_W-1:0]    rsp_index,
   output logic                          rsp_error
);

   localparam int IW = csff_pkg::IDX_W;
   localparam int CW = csff_pkg::COUNT_W;
   localparam int AW = $clog2(SLOTS);
   localparam int GROUPS = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int OW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int SW = CW + $clog2(GROUP_SIZE);
   // Reciprocal for the slot-to-group division, exact for all IW-bit slots.
   localparam int SH = IW + $clog2(GROUP_SIZE);
   localparam int RECIP = ((1 << SH) + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int MW = $clog2(RECIP + 1);
   localparam int PW = IW + MW;
   localparam int XW = IW + 2;
   localparam int BW = GW + IW + 2;
   localparam logic [16:0] SLOTS_V = 17'(SLOTS);
   localparam logic [IW-1:0] HI_MAX = IW'(SLOTS - 1);
   localparam logic [OW-1:0] OFF_LAST = OW'(GROUP_SIZE - 1);
   localparam logic [XW-1:0] GSIZE_X = XW'(GROUP_SIZE);

   logic [csff_pkg::OP_W-1:0] op_ff, op_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic range_ok_ff, range_ok_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic [OW-1:0] off_ff, off_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic res_found_ff, res_found_in;
   logic [IW-1:0] res_index_ff, res_index_in;
   logic res_error_ff, res_error_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [IW-1:0] rsp_index_ff, rsp_index_in;
   logic rsp_error_ff, rsp_error_in;
   logic [SW-1:0] grp_cnt_ff [GROUPS];
   logic [SW-1:0] grp_cnt_in [GROUPS];

   logic [CW-1:0] rd_data;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [PW-1:0] quot_prod;
   logic [BW-1:0] grp_base;
   logic [IW-1:0] hi_clamp;
   logic find_low;
   logic slot_ok;
   logic [XW-1:0] low_jump;
   logic [IW-1:0] grp_start;
   logic upd_err;
   logic upd_apply;
   logic [CW-1:0] upd_count;

   // Slot count memory.
   csff_ram #(
      .WIDTH(CW),
      .DEPTH(SLOTS)
   ) u_count_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(AW'(cur_ff)),
      .rd_data(rd_data)
   );

   // Search helpers.
   assign find_low = (op_ff == csff_pkg::OP_FIND_LOW);
   assign quot_prod = PW'(cur_ff) * PW'(RECIP);
   assign grp_base = BW'(grp_ff) * BW'(GROUP_SIZE);
   assign hi_clamp = ({7'b0, req_range_high} > 17'(HI_MAX)) ? HI_MAX : req_range_high;
   assign slot_ok = ({7'b0, cur_ff} < SLOTS_V);
   assign low_jump = XW'(cur_ff) + GSIZE_X - XW'(off_ff);
   assign grp_start = cur_ff - IW'(off_ff);

   // Update of the addressed slot.
   always_comb begin
      upd_err = 1'b0;
      upd_count = rd_data;
      if (op_ff == csff_pkg::OP_ADD) begin
         upd_err = (rd_data == csff_pkg::COUNT_MAX);
         upd_count = rd_data + CW'(1);
      end else begin
         upd_err = (rd_data == '0);
         upd_count = rd_data - CW'(1);
      end
      upd_err = upd_err && slot_ok;
      upd_apply = cmd.update && slot_ok && !upd_err;
   end

   // Memory write port: clearing sweep or slot update.
   always_comb begin
      wr_en = cmd.clear || upd_apply;
      wr_addr = cmd.clear ? clr_ff : AW'(cur_ff);
      wr_data = cmd.clear ? '0 : upd_count;
   end

   // Status to the controller.
   always_comb begin
      status.clear_last = (clr_ff == AW'(SLOTS - 1));
      status.is_update = !op_ff[1];
      status.range_ok = range_ok_ff;
      status.grp_empty = (grp_cnt_ff[grp_ff] == '0);
      status.jump_miss = find_low ? (low_jump > XW'(hi_ff)) : (grp_start <= lo_ff);
      status.at_end = find_low ? (cur_ff == hi_ff) : (cur_ff == lo_ff);
      status.data_nz = (rd_data != '0);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next values of the datapath registers.
   always_comb begin
      op_in = op_ff;
      cur_in = cur_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      range_ok_in = range_ok_ff;
      grp_in = grp_ff;
      off_in = off_ff;
      clr_in = clr_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_error_in = rsp_error_ff;
      grp_cnt_in = grp_cnt_ff;

      if (cmd.clear) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.load) begin
         op_in = req_operation;
         lo_in = req_range_low;
         hi_in = hi_clamp;
         range_ok_in = ({7'b0, req_range_low} < SLOTS_V) && (req_range_low <= hi_clamp);
         case (req_operation)
            csff_pkg::OP_FIND_LOW: cur_in = req_range_low;
            csff_pkg::OP_FIND_HIGH: cur_in = hi_clamp;
            default: cur_in = req_slot;
         endcase
      end
      if (cmd.prep) begin
         grp_in = GW'(quot_prod >> SH);
      end
      if (cmd.prep2) begin
         off_in = OW'(BW'(cur_ff) - grp_base);
      end
      // Skip a group whose sum is zero.
      if (cmd.jump) begin
         if (find_low) begin
            cur_in = IW'(low_jump);
            grp_in = grp_ff + GW'(1);
            off_in = '0;
         end else begin
            cur_in = grp_start - IW'(1);
            grp_in = grp_ff - GW'(1);
            off_in = OFF_LAST;
         end
      end
      // Step to the neighboring slot.
      if (cmd.advance) begin
         if (find_low) begin
            cur_in = cur_ff + IW'(1);
            if (off_ff == OFF_LAST) begin
               off_in = '0;
               grp_in = grp_ff + GW'(1);
            end else begin
               off_in = off_ff + OW'(1);
            end
         end else begin
            cur_in = cur_ff - IW'(1);
            if (off_ff == '0) begin
               off_in = OFF_LAST;
               grp_in = grp_ff - GW'(1);
            end else begin
               off_in = off_ff - OW'(1);
            end
         end
      end
      if (cmd.hit) begin
         res_found_in = 1'b1;
         res_index_in = cur_ff;
         res_error_in = 1'b0;
      end
      if (cmd.miss) begin
         res_found_in = 1'b0;
         res_index_in = '0;
         res_error_in = 1'b0;
      end
      if (cmd.update) begin
         res_found_in = 1'b0;
         res_index_in = '0;
         res_error_in = upd_err;
      end
      if (upd_apply) begin
         if (op_ff == csff_pkg::OP_ADD) begin
            grp_cnt_in[grp_ff] = grp_cnt_ff[grp_ff] + SW'(1);
         end else begin
            grp_cnt_in[grp_ff] = grp_cnt_ff[grp_ff] - SW'(1);
         end
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_index_in = res_index_ff;
         rsp_error_in = res_error_ff;
      end
   end

   // Control registers and group sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUPS; g++) begin
            grp_cnt_ff[g] <= '0;
         end
      end else begin
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         grp_cnt_ff <= grp_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      cur_ff <= cur_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      range_ok_ff <= range_ok_in;
      grp_ff <= grp_in;
      off_ff <= off_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      res_error_ff <= res_error_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_error = rsp_error_ff;

   // A new word is published only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   // A hit lies inside the search range.
   assert property (@(posedge clock) disable iff (reset)
      cmd.hit |-> (cur_ff >= lo_ff) && (cur_ff <= hi_ff))
      else $error("hit outside range");

   // A hit is only reported in a group with a nonzero sum.
   assert property (@(posedge clock) disable iff (reset)
      cmd.hit |-> (grp_cnt_ff[grp_ff] != '0))
      else $error("hit in empty group");

endmodule

[rtl/core/counted_set_find_first_last_in_range_top.sv]
// Top level of the counted set with range find-first and find-last.
// An add or remove passes the prepare and update states before its response is published.
// A find prepares, then jumps over each empty group and reads the slots of a nonempty
// group one by one through the single read port of the slot count memory.
// An empty or out-of-table range is answered from the prepare state. One word is
// processed at a time; a new request is taken while a response still waits. After
// reset a clearing pass zeroes the count memory before the first request.
module counted_set_find_first_last_in_range_top #(
   parameter int SLOTS = csff_pkg::SLOTS_DEF,
   parameter int GROUP_SIZE = csff_pkg::GROUP_SIZE_DEF
) (
   input logic clock,
   input logic reset,
   csff_req_if.sink req_ch,
   csff_rsp_if.source rsp_ch
);

   csff_pkg::cmd_type cmd;
   csff_pkg::status_type status;

   // Sequencing.
   csff_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .status(status),
      .cmd(cmd)
   );

   // Storage and arithmetic.
   csff_dp #(
      .SLOTS(SLOTS),
      .GROUP_SIZE(GROUP_SIZE)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_operation(req_ch.operation),
      .req_slot(req_ch.slot),
      .req_range_low(req_ch.range_low),
      .req_range_high(req_ch.range_high),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_found(rsp_ch.found),
      .rsp_index(rsp_ch.index),
      .rsp_error(rsp_ch.error)
   );

endmodule
